// ===== rtl/core/drts_pkg.sv =====
// ----------------------------------------------------------------------------
// drts_pkg: shared types and constants of the task scheduler
// Sizes, error codes, modes and the cell-to-cell structs.
// ----------------------------------------------------------------------------
package drts_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RUNNING_DEPTH = 8;
  localparam int MAX_DEPS      = 4;
  localparam int ID_WIDTH      = 16;
  localparam int QW            = $clog2(QUEUE_DEPTH + 1);
  localparam int RW            = $clog2(RUNNING_DEPTH);

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_START  = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_QUEUE_FULL = 3'd1,
    ERR_CONFLICT   = 3'd2,
    ERR_RUN_FULL   = 3'd3,
    ERR_UNKNOWN    = 3'd4,
    ERR_NOT_LOCKED = 3'd5
  } err_t;

  // One waiting task as held by a queue cell.
  typedef struct packed {
    logic [ID_WIDTH-1:0]              id;
    logic [63:0]                      stime;
    logic [63:0]                      mask;
    logic [2:0]                       dcnt;
    logic [MAX_DEPS-1:0][ID_WIDTH-1:0] deps;
  } task_t;

  // Selection token handed from cell to cell during a pop scan.
  typedef struct packed {
    logic              have;
    logic [QW-1:0]     idx;
    logic [63:0]       stime;
  } best_t;

endpackage

// ===== rtl/core/drts_cell.sv =====
// ----------------------------------------------------------------------------
// drts_cell: one slot of the waiting queue
// Holds a task, shifts toward the head on removal, and checks its own
// readiness against a broadcast waiting id and the running table.
// ----------------------------------------------------------------------------
module drts_cell
  import drts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,       // write push data
  input  task_t               load_task,
  input  logic                shift,      // take neighbor's contents
  input  task_t               nbr_task,
  input  logic                nbr_valid,
  input  logic                clr_flags,  // cleared in every request's execute step
  input  logic                probe_en,   // another waiting id presented
  input  logic [ID_WIDTH-1:0] probe_id,
  input  logic                run_blk,    // blocked by running set (comb)
  output task_t               cur,
  output logic                valid,
  output logic                ready
);

  logic blocked;
  logic probe_hit;

  always_comb begin
    probe_hit = 1'b0;
    for (int k = 0; k < MAX_DEPS; k++) begin
      if (3'(k) < cur.dcnt && cur.deps[k] == probe_id) probe_hit = 1'b1;
    end
    if (probe_id == cur.id) probe_hit = 1'b0;
  end

  assign ready = valid && !blocked && !run_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      blocked <= 1'b0;
    end else begin
      if (load) begin
        cur   <= load_task;
        valid <= 1'b1;
      end else if (shift) begin
        cur   <= nbr_task;
        valid <= nbr_valid;
      end
      if (clr_flags) blocked <= 1'b0;
      else if (probe_en && probe_hit) blocked <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/drts_run_table.sv =====
// ----------------------------------------------------------------------------
// drts_run_table: running tasks and locked resources
// Start, finish and per-task blocking checks against running entries.
// ----------------------------------------------------------------------------
module drts_run_table
  import drts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                do_start,
  input  logic                do_finish,
  input  logic [ID_WIDTH-1:0] op_id,
  input  logic [63:0]         op_mask,
  output err_t                start_err,
  output err_t                finish_err,
  output logic                any_run,
  input  task_t               chk_task,
  output logic                chk_blk
);

  logic [RUNNING_DEPTH-1:0]               rvalid;
  logic [RUNNING_DEPTH-1:0][ID_WIDTH-1:0] rid;
  logic [RUNNING_DEPTH-1:0][63:0]         rmask;
  logic [63:0]                            locked;

  logic          hit, free;
  logic [RW-1:0] hit_idx, free_idx;

  always_comb begin
    hit = 1'b0; hit_idx = '0; free = 1'b0; free_idx = '0;
    for (int r = RUNNING_DEPTH - 1; r >= 0; r--) begin
      if (rvalid[r] && rid[r] == op_id) begin
        hit = 1'b1; hit_idx = RW'(r);
      end
      if (!rvalid[r]) begin
        free = 1'b1; free_idx = RW'(r);
      end
    end
    if ((op_mask & locked) != '0)   start_err = ERR_CONFLICT;
    else if (!hit && !free)         start_err = ERR_RUN_FULL;
    else                            start_err = ERR_OK;
    if (!hit)                                    finish_err = ERR_UNKNOWN;
    else if ((rmask[hit_idx] & ~locked) != '0)   finish_err = ERR_NOT_LOCKED;
    else                                         finish_err = ERR_OK;
  end

  assign any_run = |rvalid;

  always_comb begin
    chk_blk = 1'b0;
    for (int r = 0; r < RUNNING_DEPTH; r++) begin
      if (rvalid[r]) begin
        if ((rmask[r] & chk_task.mask) != '0) chk_blk = 1'b1;
        for (int k = 0; k < MAX_DEPS; k++) begin
          if (3'(k) < chk_task.dcnt && chk_task.deps[k] == rid[r]) chk_blk = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
      locked <= '0;
    end else if (do_start && start_err == ERR_OK) begin
      locked <= locked | op_mask;
      if (hit) begin
        rmask[hit_idx] <= rmask[hit_idx] | op_mask;
      end else begin
        rvalid[free_idx] <= 1'b1;
        rid[free_idx]    <= op_id;
        rmask[free_idx]  <= op_mask;
      end
    end else if (do_finish && finish_err == ERR_OK) begin
      locked          <= locked & ~rmask[hit_idx];
      rvalid[hit_idx] <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/dependency_resource_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// dependency_resource_task_scheduler: dependency and resource aware scheduler
// Waiting queue as a row of cells plus a running-task table.
// ----------------------------------------------------------------------------
// One request in, one response out. Push, start and finish pass from
// acceptance through the execute state to the output register. Pop scans
// the queue of waiting cells: it broadcasts the id of each waiting task to
// every cell (dependency check), then passes the best-so-far token down the
// row, then reads out the chosen task while the row behind it shifts up.
// The shift step is skipped when nothing is ready, and the whole scan when
// the queue is empty. A new request is taken once the previous one is
// finished, even if its response is still held in the output register.
module dependency_resource_task_scheduler
  import drts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: mode[1:0], task_id[17:2], start_time[81:18], now_time[145:82],
  // resource_mask[209:146], dep_count[212:210], dep_a..dep_d[276:213], pad
  input  logic [279:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: found[0], out_task_id[16:1], out_start_time[80:17],
  // out_resource_mask[144:81], must_wait[145], error_code[148:146], pad
  output logic [151:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_PROBE, ST_SCAN, ST_SHIFT, ST_OUT
  } state_t;

  state_t          state;
  logic [279:0]    req;
  logic [QW-1:0]   cnt;     // tasks waiting
  logic [QW-1:0]   ptr;     // scan position
  best_t           best;
  logic [151:0]    resp;      // response being built
  logic [151:0]    resp_out;  // output register
  logic            resp_pend;

  mode_t          req_mode;
  logic [2:0]     dc_sat;
  task_t          push_task;
  err_t           exec_err;

  assign req_mode = mode_t'(req[1:0]);
  assign dc_sat   = (req[212:210] > 3'(MAX_DEPS)) ? 3'(MAX_DEPS) : req[212:210];

  always_comb begin
    push_task.id    = req[17:2];
    push_task.stime = req[81:18];
    push_task.mask  = req[209:146];
    push_task.dcnt  = dc_sat;
    for (int k = 0; k < MAX_DEPS; k++) begin
      push_task.deps[k] = (3'(k) < dc_sat) ? req[213 + 16*k +: 16] : '0;
    end
  end

  // Cell row
  task_t [QUEUE_DEPTH-1:0]  ctask;
  logic  [QUEUE_DEPTH-1:0]  cvalid, cready, cload, cshift, crun_blk;
  task_t                    sel_task;
  logic  [QUEUE_DEPTH-1:0]  sel_ready;
  logic                     any_run, chk_blk;
  err_t                     start_err, finish_err;
  logic                     ptr_ready, late, hand_out, take, out_load;

  assign sel_task = ctask[ptr[$clog2(QUEUE_DEPTH)-1:0]];

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign cload[g]    = state == ST_EXEC && req_mode == MODE_PUSH &&
                           cnt < QW'(QUEUE_DEPTH) && cnt == QW'(g);
      assign cshift[g]   = state == ST_SHIFT && hand_out && QW'(g) >= ptr;
      assign crun_blk[g] = (QW'(g) == ptr) ? chk_blk : 1'b0;
      drts_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load     (cload[g]),
        .load_task(push_task),
        .shift    (cshift[g]),
        .nbr_task ((g == QUEUE_DEPTH - 1) ? ctask[g] : ctask[(g + 1) % QUEUE_DEPTH]),
        .nbr_valid((g == QUEUE_DEPTH - 1) ? 1'b0 : cvalid[(g + 1) % QUEUE_DEPTH]),
        .clr_flags(state == ST_EXEC),
        .probe_en (state == ST_PROBE),
        .probe_id (sel_task.id),
        .run_blk  (crun_blk[g]),
        .cur      (ctask[g]),
        .valid    (cvalid[g]),
        .ready    (cready[g])
      );
    end
  endgenerate
  assign sel_ready = cready;

  drts_run_table u_run (
    .clk       (clk),
    .rst       (rst),
    .do_start  (state == ST_EXEC && req_mode == MODE_START),
    .do_finish (state == ST_EXEC && req_mode == MODE_FINISH),
    .op_id     (req[17:2]),
    .op_mask   (req[209:146]),
    .start_err (start_err),
    .finish_err(finish_err),
    .any_run   (any_run),
    .chk_task  (sel_task),
    .chk_blk   (chk_blk)
  );

  assign ptr_ready = sel_ready[ptr[$clog2(QUEUE_DEPTH)-1:0]];
  assign late      = best.stime > req[145:82];
  // a late task is only handed out (with must_wait) when nothing runs
  assign hand_out  = !late || !any_run;
  // strictly earlier start time wins, so ties stay with the older push
  assign take      = ptr_ready && (!best.have || best.stime > sel_task.stime);
  assign out_load  = state == ST_OUT && (!resp_pend || m_tready);

  always_comb begin
    case (req_mode)
      MODE_PUSH:   exec_err = (cnt >= QW'(QUEUE_DEPTH)) ? ERR_QUEUE_FULL : ERR_OK;
      MODE_START:  exec_err = start_err;
      MODE_FINISH: exec_err = finish_err;
      default:     exec_err = ERR_OK;
    endcase
  end

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = resp_pend;
  assign m_tdata  = resp_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      resp_pend <= 1'b0;
      best      <= '0;
    end else begin
      if (out_load) begin
        resp_out  <= resp;
        resp_pend <= 1'b1;
      end else if (m_tready) resp_pend <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req   <= s_tdata;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          resp <= {3'b000, exec_err, 146'd0};
          ptr  <= '0;
          best <= '0;
          case (req_mode)
            MODE_PUSH: begin
              if (cnt < QW'(QUEUE_DEPTH)) cnt <= cnt + 1'b1;
              state <= ST_OUT;
            end
            MODE_POP:    state <= (cnt == '0) ? ST_OUT : ST_PROBE;
            default:     state <= ST_OUT;
          endcase
        end
        ST_PROBE: begin
          // broadcast each waiting id once
          if (ptr + 1'b1 >= cnt) begin
            ptr   <= '0;
            state <= ST_SCAN;
          end else ptr <= ptr + 1'b1;
        end
        ST_SCAN: begin
          if (take) best <= {1'b1, ptr, sel_task.stime};
          if (ptr + 1'b1 >= cnt) begin
            // last cell may be the winner; then ptr already points at it
            if (take) state <= ST_SHIFT;
            else if (best.have) begin
              ptr   <= best.idx;
              state <= ST_SHIFT;
            end else state <= ST_OUT;
          end else ptr <= ptr + 1'b1;
        end
        ST_SHIFT: begin
          // ptr points at the chosen cell; if handed out, output it and shift the row
          if (hand_out) begin
            resp <= {3'b000, ERR_OK, late, sel_task.mask, sel_task.stime,
                     sel_task.id, 1'b1};
            cnt  <= cnt - 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The row shifts only when the pop hands the task out.

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_one_resp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!resp_pend || m_tready)) |=> m_tvalid)
    else $error("response lost");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(state == ST_SHIFT)) else $error("ready while busy");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the task scheduler
// Streams push/pop/start/finish requests under random idling, predicts each
// response with a behavioral model of queue and running table, and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import drts_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [279:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [151:0] m_tdata;

  dependency_resource_task_scheduler DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // field order from the top bit down, matching m_tdata[148:0]
  typedef struct packed {
    logic [2:0]   err;
    logic         late;
    logic [63:0]  mask;
    logic [63:0]  stime;
    logic [15:0]  tid;
    logic         found;
  } resp_t;

  // predictor state
  logic [15:0] q_id   [QUEUE_DEPTH];
  logic [63:0] q_time [QUEUE_DEPTH];
  logic [63:0] q_mask [QUEUE_DEPTH];
  int          q_dc   [QUEUE_DEPTH];
  logic [15:0] q_deps [QUEUE_DEPTH][MAX_DEPS];
  int          q_len;
  logic        r_valid [RUNNING_DEPTH];
  logic [15:0] r_id    [RUNNING_DEPTH];
  logic [63:0] r_mask  [RUNNING_DEPTH];
  logic [63:0] locked;

  logic [279:0] pending_reqs[$];
  resp_t        expected_resps[$];
  int           errors;
  int           n_bad;
  longint       cycle;
  bit           calm;       // no idling near the end
  int           hold_off;   // long receiver stall
  int           s_gap, m_gap;

  function automatic logic [279:0] pack_req(mode_t m, logic [15:0] id, logic [63:0] st,
                                            logic [63:0] nw, logic [63:0] msk,
                                            logic [2:0] dc, logic [63:0] deps);
    logic [279:0] d;
    d = '0;
    d[1:0] = m; d[17:2] = id; d[81:18] = st; d[145:82] = nw;
    d[209:146] = msk; d[212:210] = dc; d[276:213] = deps;
    return d;
  endfunction

  function automatic void queue_req(logic [279:0] d);
    pending_reqs = {pending_reqs, d};
  endfunction

  function automatic bit task_ready(int i);
    for (int j = 0; j < q_len; j++) begin
      if (q_id[j] == q_id[i]) continue;
      for (int k = 0; k < q_dc[i]; k++)
        if (q_deps[i][k] == q_id[j]) return 0;
    end
    for (int r = 0; r < RUNNING_DEPTH; r++) begin
      if (!r_valid[r]) continue;
      for (int k = 0; k < q_dc[i]; k++)
        if (q_deps[i][k] == r_id[r]) return 0;
      if ((r_mask[r] & q_mask[i]) != 0) return 0;
    end
    return 1;
  endfunction

  // Applies one request to the model, returns the response it should produce.
  function automatic resp_t schedule_step(logic [279:0] d);
    resp_t o;
    mode_t m;
    logic [15:0] id;
    logic [63:0] msk;
    int dc, best, r, hit;
    bit have, late, busy;
    o = '0;
    m = mode_t'(d[1:0]);
    id = d[17:2];
    msk = d[209:146];
    case (m)
      MODE_PUSH: begin
        if (q_len >= QUEUE_DEPTH) o.err = ERR_QUEUE_FULL;
        else begin
          dc = d[212:210];
          if (dc > MAX_DEPS) dc = MAX_DEPS;
          q_id[q_len] = id; q_time[q_len] = d[81:18]; q_mask[q_len] = msk;
          q_dc[q_len] = dc;
          for (int k = 0; k < MAX_DEPS; k++)
            q_deps[q_len][k] = (k < dc) ? d[213+16*k +: 16] : 16'd0;
          q_len++;
        end
      end
      MODE_POP: begin
        have = 0; best = 0;
        for (int i = 0; i < q_len; i++)
          if (task_ready(i) && (!have || q_time[best] > q_time[i])) begin
            best = i; have = 1;
          end
        busy = 0;
        for (int k = 0; k < RUNNING_DEPTH; k++) busy |= r_valid[k];
        if (have) begin
          late = q_time[best] > d[145:82];
          if (!late || !busy) begin
            o.found = 1; o.tid = q_id[best]; o.stime = q_time[best];
            o.mask = q_mask[best]; o.late = late;
            for (int j = best; j + 1 < q_len; j++) begin
              q_id[j] = q_id[j+1]; q_time[j] = q_time[j+1];
              q_mask[j] = q_mask[j+1]; q_dc[j] = q_dc[j+1];
              q_deps[j] = q_deps[j+1];
            end
            q_len--;
          end
        end
      end
      MODE_START: begin
        if ((msk & locked) != 0) o.err = ERR_CONFLICT;
        else begin
          hit = -1;
          for (int k = RUNNING_DEPTH - 1; k >= 0; k--)
            if (r_valid[k] && r_id[k] == id) hit = k;
          if (hit >= 0) r_mask[hit] |= msk;
          else begin
            r = -1;
            for (int k = RUNNING_DEPTH - 1; k >= 0; k--) if (!r_valid[k]) r = k;
            if (r < 0) o.err = ERR_RUN_FULL;
            else begin
              r_valid[r] = 1; r_id[r] = id; r_mask[r] = msk;
            end
          end
          if (o.err == ERR_OK) locked |= msk;
        end
      end
      default: begin
        r = -1;
        for (int k = RUNNING_DEPTH - 1; k >= 0; k--)
          if (r_valid[k] && r_id[k] == id) r = k;
        if (r < 0) o.err = ERR_UNKNOWN;
        else if ((r_mask[r] & ~locked) != 0) o.err = ERR_NOT_LOCKED;
        else begin
          locked &= ~r_mask[r];
          r_valid[r] = 0; r_id[r] = 0; r_mask[r] = 0;
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Sparse masks so that tasks do not always collide; occasionally full.
  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return rand64();
      2: return '1;
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  // Small id pool so dependencies and finishes actually hit.
  function automatic logic [15:0] rand_id();
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 11));
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // stimulus
  initial begin
    logic [63:0] deps;
    int md;
    // directed: extremes, all modes, special cases
    queue_req(pack_req(MODE_FINISH, 16'd3, 0, 0, 0, 0, 0)); // unknown task
    queue_req(pack_req(MODE_POP, 0, 0, '1, 0, 0, 0));       // nothing ready
    queue_req(pack_req(MODE_PUSH, 16'hFFFF, '1, 0, '1, 3'd7, '1)); // dc saturates
    queue_req(pack_req(MODE_PUSH, 16'd1, 64'd100, 0, 64'h1, 3'd0, 0));
    queue_req(pack_req(MODE_PUSH, 16'd2, 64'd100, 0, 64'h2, 3'd1, 64'd1));
    queue_req(pack_req(MODE_POP, 0, 0, 64'd500, 0, 0, 0));  // earliest, tie with a blocked task
    queue_req(pack_req(MODE_START, 16'd1, 0, 0, 64'h1, 0, 0));
    queue_req(pack_req(MODE_START, 16'd1, 0, 0, 64'h1, 0, 0)); // conflict
    queue_req(pack_req(MODE_START, 16'd1, 0, 0, 64'h4, 0, 0)); // merge
    queue_req(pack_req(MODE_POP, 0, 0, 64'd0, 0, 0, 0));   // nothing ready while task 1 runs
    queue_req(pack_req(MODE_FINISH, 16'd1, 0, 0, 0, 0, 0));
    queue_req(pack_req(MODE_POP, 0, 0, 64'd0, 0, 0, 0));   // late, idle: wait
    for (int i = 0; i < 8; i++)
      queue_req(pack_req(MODE_START, 16'(10 + i), 0, 0, 64'd1 << (8 + i), 0, 0));
    queue_req(pack_req(MODE_START, 16'd40, 0, 0, 64'd1 << 40, 0, 0)); // run full
    for (int i = 0; i < 8; i++)
      queue_req(pack_req(MODE_FINISH, 16'(10 + i), 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)                                        // queue full
      queue_req(pack_req(MODE_PUSH, 16'(20 + i), rand64(), 0, rand_mask(),
                         3'd0, 0));
    for (int i = 0; i < 18; i++)
      queue_req(pack_req(MODE_POP, 0, 0, '1, 0, 0, 0));
    // random: mostly push/pop/start/finish cycles over a small id pool
    for (int i = 0; i < 1000; i++) begin
      md = $urandom_range(0, 9);
      deps = {rand_id(), rand_id(), rand_id(), rand_id()};
      if (md < 4)
        queue_req(pack_req(MODE_PUSH, rand_id(),
          ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 300)),
          rand64(), rand_mask(), 3'($urandom_range(0, 7)), deps));
      else if (md < 7)
        queue_req(pack_req(MODE_POP, rand_id(), rand64(),
          ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 300)),
          rand64(), 3'($urandom_range(0, 7)), rand64()));
      else if (md < 9)
        queue_req(pack_req(mode_t'(md < 8 ? MODE_START : MODE_FINISH),
          rand_id(), rand64(), rand64(), rand_mask(), 3'($urandom_range(0, 7)), rand64()));
      else
        queue_req(pack_req(MODE_FINISH, rand_id(), rand64(), rand64(),
          rand64(), 3'($urandom_range(0, 7)), rand64()));
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata  <= '0;
      s_gap    <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_resps = {expected_resps, schedule_step(s_tdata)};
        void'(pending_reqs.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // keep offering the same request
      end else if (s_gap > 0) begin
        s_gap    <= s_gap - 1;
        s_tvalid <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        s_gap    <= $urandom_range(0, 4);
        s_tvalid <= 0;
      end else if (pending_reqs.size() > 0) begin
        s_tvalid <= 1;
        s_tdata  <= pending_reqs[0];
      end else s_tvalid <= 0;
    end
  end

  // long receiver stall, counted on its own
  always @(posedge clk) begin
    if (rst) hold_off <= 0;
    else if (cycle == 3000) hold_off <= 400;   // block fills and backs up
    else if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    resp_t got, want;
    if (rst) begin
      m_tready <= 0;
      m_gap    <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[148:0];
        if (expected_resps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response %h", got);
        end else begin
          want = expected_resps.pop_front();
          n_bad = 0;
          if (got.found !== want.found) n_bad++;
          if (got.tid   !== want.tid)   n_bad++;
          if (got.stime !== want.stime) n_bad++;
          if (got.mask  !== want.mask)  n_bad++;
          if (got.late  !== want.late)  n_bad++;
          if (got.err   !== want.err)   n_bad++;
          if (n_bad != 0) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp f=%0d id=%h t=%h m=%h w=%0d e=%0d",
                        "  got f=%0d id=%h t=%h m=%h w=%0d e=%0d"},
                       want.found, want.tid, want.stime, want.mask, want.late, want.err,
                       got.found, got.tid, got.stime, got.mask, got.late, got.err);
          end
        end
      end
      if (hold_off > 0) begin
        m_tready <= 0;
      end else if (m_gap > 0) begin
        m_gap    <= m_gap - 1;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        m_gap    <= $urandom_range(0, 4);
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end

  always @(posedge clk) cycle <= cycle + 1;

  initial begin
    errors = 0;
    cycle  = 0;
    calm   = 0;
    q_len  = 0;
    locked = 0;
    for (int k = 0; k < RUNNING_DEPTH; k++) begin
      r_valid[k] = 0; r_id[k] = 0; r_mask[k] = 0;
    end
    rst = 1;
    s_tvalid = 0; s_tdata = '0; m_tready = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    wait (pending_reqs.size() < 150);
    calm = 1;
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog in case the run hangs; it leaves wide margin over pops and stalls.
  initial begin
    wait (cycle >= 1000000);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/drts_pkg.sv
rtl/core/drts_cell.sv
rtl/core/drts_run_table.sv
rtl/core/dependency_resource_task_scheduler.sv
bench/tb_top.sv
